// ===== sv/pls_pkg.sv =====
// Shared constants and item types of the piecewise-linear speed profile unit.
package pls_pkg;

  localparam int unsigned MaxAnchors = 8;
  localparam int unsigned IdxW       = $clog2(MaxAnchors);
  localparam int unsigned CntW       = $clog2(MaxAnchors + 1);
  localparam int unsigned DivSteps   = 32;

  localparam logic [1:0] ActLoad  = 2'd0;
  localparam logic [1:0] ActClear = 2'd1;

  typedef enum logic [2:0] {
    StLoaded   = 3'd0,
    StFull     = 3'd1,
    StIgnored  = 3'd2,
    StAnchors  = 3'd3,
    StFallback = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] position_mm;
    logic [31:0]        speed_value;
  } pls_in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] speed_out;
    logic        has_anchors;
  } pls_out_t;

endpackage

// ===== sv/piecewise_linear_speed_profile_unit.sv =====
// Piecewise-linear speed profile: sorted anchor table, sequencer and shared arithmetic unit.
// A clear, a fallback query or an ignored or dropped load goes straight to the result; a load
// moves larger anchors up one slot at a time; a query held at an end anchor stops once an
// end check catches it; an interpolating query walks up the table, takes an extra step when the
// speed falls and divides with the 32-step divider. One item at a time; the next is taken once the
// result sits in the output register. Asynchronous active-low reset: empty table, zero fallback.
module piecewise_linear_speed_profile_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pls_pkg::pls_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pls_pkg::pls_out_t  out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);
  import pls_pkg::*;

  localparam int unsigned StepW = $clog2(DivSteps);

  // One anchor as held in the table memory.
  typedef struct packed {
    logic signed [31:0] pos;
    logic [31:0]        spd;
  } anchor_t;

  // The sequencer. Loads walk down from the top of the table, shifting larger positions
  // up by one until the new anchor's slot is found (an insertion-sort step). Queries check
  // both ends first, then walk upwards for the bracketing pair and interpolate.
  typedef enum logic [3:0] {
    SIdle,
    SDone,
    SInsStep,
    SInsCmp,
    SQChk0,
    SQChkN,
    SQWalk,
    SQNum,
    SQDen,
    SQMag,
    SQMagNeg,
    SQMul,
    SQDiv,
    SQFin
  } state_e;

  state_e             state_q;
  logic signed [31:0] pos_q;
  logic [31:0]        spd_q;
  logic [CntW-1:0]    count_q;
  logic [IdxW-1:0]    idx_q;
  anchor_t            prev_q;
  anchor_t            cur_q;
  logic [31:0]        num_q;
  logic [31:0]        den_q;
  logic [31:0]        mag_q;
  logic               up_q;
  logic [31:0]        rem_q;
  logic [31:0]        low_q;
  logic [31:0]        quot_q;
  logic [StepW-1:0]   step_q;
  status_e            res_status_q;
  logic [31:0]        res_speed_q;
  logic               out_valid_q;
  pls_out_t           out_q;
  logic [31:0]        fallback_q;

  // Anchor table: one write and one registered read port.
  anchor_t         mem [MaxAnchors];
  anchor_t         rdata_q;
  logic [IdxW-1:0] raddr;
  logic [IdxW-1:0] waddr;
  logic            we;
  anchor_t         wdata;

  // The shared unit: one 34-bit adder/subtractor serves every compare, every difference,
  // each division step and the final correction. Its operands are wide enough that signed
  // positions and unsigned speeds never overflow.
  logic signed [33:0] alu_a;
  logic signed [33:0] alu_b;
  logic               alu_sub;
  logic signed [33:0] alu_y;
  logic               alu_neg;
  logic               alu_zero;
  logic [63:0]        prod;
  logic               accept;

  assign alu_y    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_neg  = alu_y[33];
  assign alu_zero = (alu_y == '0);
  assign prod     = 64'(mag_q) * 64'(num_q);

  assign in_stall_o  = (state_q != SIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Operand selection for the shared unit. By default it compares the item's position
  // with the anchor just read from the table.
  always_comb begin
    alu_a   = {{2{pos_q[31]}}, pos_q};
    alu_b   = {{2{rdata_q.pos[31]}}, rdata_q.pos};
    alu_sub = 1'b1;
    case (state_q)
      SQNum: begin
        alu_b = {{2{prev_q.pos[31]}}, prev_q.pos};
      end
      SQDen: begin
        alu_a = {{2{cur_q.pos[31]}}, cur_q.pos};
        alu_b = {{2{prev_q.pos[31]}}, prev_q.pos};
      end
      SQMag: begin
        alu_a = {2'b00, cur_q.spd};
        alu_b = {2'b00, prev_q.spd};
      end
      SQMagNeg: begin
        alu_a = {2'b00, prev_q.spd};
        alu_b = {2'b00, cur_q.spd};
      end
      SQDiv: begin
        alu_a = {1'b0, rem_q, low_q[31]};
        alu_b = {2'b00, den_q};
      end
      SQFin: begin
        alu_a   = {2'b00, prev_q.spd};
        alu_b   = {2'b00, quot_q};
        alu_sub = !up_q;
      end
      default: begin
      end
    endcase
  end

  // Table addressing. In idle the read port points at the first anchor so that a query
  // finds it ready in the cycle after acceptance.
  always_comb begin
    raddr     = '0;
    waddr     = idx_q;
    we        = 1'b0;
    wdata     = rdata_q;
    case (state_q)
      SInsStep: begin
        raddr = idx_q - IdxW'(1);
        if (idx_q == '0) begin
          we        = 1'b1;
          wdata.pos = pos_q;
          wdata.spd = spd_q;
        end
      end
      SInsCmp: begin
        we = 1'b1;
        if (!alu_neg) begin
          wdata.pos = pos_q;
          wdata.spd = spd_q;
        end
      end
      SQChk0: begin
        raddr = count_q[IdxW-1:0] - IdxW'(1);
      end
      SQChkN: begin
        raddr = IdxW'(1);
      end
      SQWalk: begin
        raddr = idx_q + IdxW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      fallback_q   <= '0;
      res_status_q <= StLoaded;
      res_speed_q  <= '0;
      idx_q        <= '0;
      step_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        fallback_q <= cfg_data_i;
      end
      // The done state refills the output register itself when it is taken.
      if (out_valid_q && !out_stall_i && (state_q != SDone)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        SIdle: begin
          if (accept) begin
            pos_q       <= in_data_i.position_mm;
            spd_q       <= in_data_i.speed_value;
            // Only a query on an empty table answers with a speed straight away.
            res_speed_q <= (in_data_i.action[1] && count_q == '0) ? fallback_q : '0;
            if (in_data_i.action[1]) begin
              // Both query codes, the unused one included.
              if (count_q == '0) begin
                res_status_q <= StFallback;
                state_q      <= SDone;
              end else begin
                res_status_q <= StAnchors;
                state_q      <= SQChk0;
              end
            end else if (in_data_i.action == ActClear) begin
              count_q      <= '0;
              res_status_q <= StLoaded;
              state_q      <= SDone;
            end else if (in_data_i.speed_value == '0) begin
              res_status_q <= StIgnored;
              state_q      <= SDone;
            end else if (count_q == CntW'(MaxAnchors)) begin
              res_status_q <= StFull;
              state_q      <= SDone;
            end else begin
              res_status_q <= StLoaded;
              idx_q        <= count_q[IdxW-1:0];
              state_q      <= SInsStep;
            end
          end
        end

        SInsStep: begin
          if (idx_q == '0) begin
            count_q <= count_q + CntW'(1);
            state_q <= SDone;
          end else begin
            state_q <= SInsCmp;
          end
        end

        SInsCmp: begin
          // A stored anchor strictly beyond the new position moves up; equal ones stay.
          if (alu_neg) begin
            idx_q   <= idx_q - IdxW'(1);
            state_q <= SInsStep;
          end else begin
            count_q <= count_q + CntW'(1);
            state_q <= SDone;
          end
        end

        SQChk0: begin
          prev_q <= rdata_q;
          if (count_q == CntW'(1) || alu_neg || alu_zero) begin
            res_speed_q <= rdata_q.spd;
            state_q     <= SDone;
          end else begin
            state_q <= SQChkN;
          end
        end

        SQChkN: begin
          if (!alu_neg) begin
            res_speed_q <= rdata_q.spd;
            state_q     <= SDone;
          end else begin
            idx_q   <= IdxW'(1);
            state_q <= SQWalk;
          end
        end

        SQWalk: begin
          // The position lies strictly inside the table, so this walk always ends on an
          // anchor at or above it, with the previous anchor strictly below.
          if (alu_neg || alu_zero) begin
            cur_q   <= rdata_q;
            state_q <= SQNum;
          end else begin
            prev_q  <= rdata_q;
            idx_q   <= idx_q + IdxW'(1);
          end
        end

        SQNum: begin
          num_q   <= alu_y[31:0];
          state_q <= SQDen;
        end

        SQDen: begin
          den_q   <= alu_y[31:0];
          state_q <= SQMag;
        end

        SQMag: begin
          up_q  <= !alu_neg;
          mag_q <= alu_y[31:0];
          if (alu_neg) begin
            state_q <= SQMagNeg;
          end else begin
            state_q <= SQMul;
          end
        end

        SQMagNeg: begin
          mag_q   <= alu_y[31:0];
          state_q <= SQMul;
        end

        SQMul: begin
          // The offset is below the span, so the upper half is already below the divisor
          // and the quotient fits in 32 bits.
          rem_q   <= prod[63:32];
          low_q   <= prod[31:0];
          quot_q  <= '0;
          step_q  <= '0;
          state_q <= SQDiv;
        end

        SQDiv: begin
          if (!alu_neg) begin
            rem_q <= alu_y[31:0];
          end else begin
            rem_q <= {rem_q[30:0], low_q[31]};
          end
          quot_q <= {quot_q[30:0], !alu_neg};
          low_q  <= {low_q[30:0], 1'b0};
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(DivSteps - 1)) begin
            state_q <= SQFin;
          end
        end

        SQFin: begin
          res_speed_q <= alu_y[31:0];
          state_q     <= SDone;
        end

        SDone: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.status      <= res_status_q;
            out_q.speed_out   <= res_speed_q;
            out_q.has_anchors <= (count_q != '0);
            out_valid_q       <= 1'b1;
            state_q           <= SIdle;
          end
        end

        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

endmodule

// ===== tb/pls_profile_checker.sv =====
// Checker for the speed profile unit: watches all three channels, predicts and compares.
module pls_profile_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  pls_pkg::pls_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  pls_pkg::pls_out_t out_data_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [31:0]       cfg_data_i,
  output int unsigned       results_o,
  output int unsigned       failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  logic [31:0]        fallback_q;
  logic signed [31:0] anchor_pos [MaxAnchors];
  logic [31:0]        anchor_spd [MaxAnchors];
  int unsigned        anchor_cnt;
  pls_out_t           profile_answers_q[$];
  pls_out_t           want;
  int unsigned        mismatches;
  int unsigned        results_seen;

  // Speed at a position from a non-empty table; the step is truncated toward zero.
  function automatic logic [31:0] speed_at(input logic signed [31:0] p);
    logic signed [31:0] lo, hi;
    logic [31:0]        s0, s1;
    logic [63:0]        num, den, mag, q;
    if (anchor_cnt == 1) return anchor_spd[0];
    if (p <= anchor_pos[0]) return anchor_spd[0];
    if (p >= anchor_pos[anchor_cnt-1]) return anchor_spd[anchor_cnt-1];
    for (int i = 0; i + 1 < anchor_cnt; i++) begin
      lo = anchor_pos[i];
      hi = anchor_pos[i+1];
      if (p >= lo && p <= hi) begin
        s0 = anchor_spd[i];
        s1 = anchor_spd[i+1];
        if (hi <= lo) return s0;
        num = 64'(longint'(p) - longint'(lo));
        den = 64'(longint'(hi) - longint'(lo));
        mag = (s1 >= s0) ? 64'(s1 - s0) : 64'(s0 - s1);
        q   = (mag * num) / den;
        return (s1 >= s0) ? s0 + q[31:0] : s0 - q[31:0];
      end
    end
    return anchor_spd[anchor_cnt-1];
  endfunction

  // Applies one item to the predicted table and returns the answer it should give.
  function automatic pls_out_t step_profile(input pls_in_t item);
    pls_out_t    res;
    int unsigned j;
    res.speed_out = '0;
    if (item.action[1]) begin
      if (anchor_cnt == 0) begin
        res.status    = StFallback;
        res.speed_out = fallback_q;
      end else begin
        res.status    = StAnchors;
        res.speed_out = speed_at(item.position_mm);
      end
    end else if (item.action == ActClear) begin
      anchor_cnt = 0;
      res.status = StLoaded;
    end else if (item.speed_value == '0) begin
      res.status = StIgnored;
    end else if (anchor_cnt >= MaxAnchors) begin
      res.status = StFull;
    end else begin
      // Insert after every anchor at or below the new position, so ties keep load order.
      j = 0;
      while (j < anchor_cnt && anchor_pos[j] <= item.position_mm) j++;
      for (int k = anchor_cnt; k > j; k--) begin
        anchor_pos[k] = anchor_pos[k-1];
        anchor_spd[k] = anchor_spd[k-1];
      end
      anchor_pos[j] = item.position_mm;
      anchor_spd[j] = item.speed_value;
      anchor_cnt++;
      res.status = StLoaded;
    end
    res.has_anchors = (anchor_cnt != 0);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q   = '0;
      anchor_cnt   = 0;
      mismatches   = 0;
      results_seen = 0;
      profile_answers_q.delete();
      results_o  <= 0;
      failures_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (profile_answers_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d speed %h",
                   $time, out_data_i.status, out_data_i.speed_out);
          mismatches++;
        end else begin
          want = profile_answers_q.pop_front();
          if (out_data_i.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     out_data_i.status);
            mismatches++;
          end
          if (out_data_i.speed_out !== want.speed_out) begin
            $display("%0t: speed_out expected %h, got %h", $time, want.speed_out,
                     out_data_i.speed_out);
            mismatches++;
          end
          if (out_data_i.has_anchors !== want.has_anchors) begin
            $display("%0t: has_anchors expected %0b, got %0b", $time, want.has_anchors,
                     out_data_i.has_anchors);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) fallback_q = cfg_data_i;
      if (in_valid_i && !in_stall_i) profile_answers_q.push_back(step_profile(in_data_i));
      results_o  <= results_seen;
      // Answers still awaited count against the run once it is over.
      failures_o <= mismatches + profile_answers_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the speed profile testbench: clock, reset, stimulus, back-pressure and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  // Queries are decoded by the top bit of the action, so both upper codes ask for a speed.
  localparam logic [1:0] ActQuery    = 2'd2;
  localparam logic [1:0] ActQueryAlt = 2'd3;

  localparam int unsigned RandomItems   = 700;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned CycleLimit    = 600000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  pls_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pls_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  int unsigned results_seen;
  int unsigned failures;
  int unsigned n_sent      = 0;
  int unsigned cycle_count = 0;
  bit          hold_off_req = 1'b0;

  // Positions loaded since the last clear, kept only so that queries land on and
  // around the anchors rather than always far away from them.
  logic signed [31:0] anchor_pos_q[$];

  piecewise_linear_speed_profile_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  pls_profile_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .results_o   (results_seen),
    .failures_o  (failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A hung handshake must not keep the run going for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: stalls of random length, mostly short with a few long ones, separated by
  // runs without any stall. When the stimulus asks for a hold-off, the stall is held for
  // a long stretch so that the block fills up and has to stall its own input.
  initial begin
    int unsigned stall_len, run_len, pick;
    wait (rst_n);
    forever begin
      pick = $urandom_range(0, 19);
      if (pick < 10) stall_len = 0;
      else if (pick < 17) stall_len = $urandom_range(1, 3);
      else if (pick < 19) stall_len = $urandom_range(4, 10);
      else stall_len = $urandom_range(20, 60);
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      if (hold_off_req) begin
        stall_len    = HoldOffCycles;
        hold_off_req = 1'b0;
      end
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      // A run ends early when a hold-off is requested, so that it starts at once.
      for (int k = 1; k < run_len && !hold_off_req; k++) @(posedge clk);
    end
  end

  // Offers one item and waits for it to be taken. Unless the item is part of a burst,
  // a random gap follows: mostly none or a few cycles, now and then a long one.
  task automatic send_item(input logic [1:0] act, input logic signed [31:0] pos,
                           input logic [31:0] spd, input bit burst);
    int unsigned gap, pick;
    in_valid <= 1'b1;
    in_data  <= '{action: act, position_mm: pos, speed_value: spd};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    if (act == ActClear) anchor_pos_q.delete();
    else if (act == ActLoad && spd != '0 && anchor_pos_q.size() < MaxAnchors)
      anchor_pos_q.push_back(pos);
    if (!burst) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) gap = 0;
      else if (pick < 16) gap = $urandom_range(1, 3);
      else if (pick < 19) gap = $urandom_range(4, 12);
      else gap = $urandom_range(30, 60);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Lowers valid and waits until every item sent so far has had its answer.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_seen < n_sent) @(posedge clk);
  endtask

  // Writes the fallback speed; only called while the block is idle.
  task automatic write_fallback(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Anchor speeds: full range half of the time, plus small values and the extremes.
  function automatic logic [31:0] pick_speed();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom;
      2:       return $urandom_range(1, 262144);
      default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0001;
    endcase
  endfunction

  // Query positions: on an anchor, just beside one, between two, within -2000 to 2000, or anywhere at all.
  function automatic logic signed [31:0] pick_query_pos();
    logic signed [31:0] a, b;
    if (anchor_pos_q.size() == 0) return $urandom;
    a = anchor_pos_q[$urandom_range(0, anchor_pos_q.size() - 1)];
    b = anchor_pos_q[$urandom_range(0, anchor_pos_q.size() - 1)];
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return a;
      2:       return a + (int'($urandom_range(0, 6)) - 3);
      3:       return 32'((longint'(a) + longint'(b)) / 2);
      default: return int'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  initial begin
    int unsigned        n_random, n_loads, n_queries;
    logic signed [31:0] load_pos;
    bit                 phase_burst;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty table answers with the fallback, through either query code.
    write_fallback(32'h1234_5678);
    send_item(ActQuery, 32'sd0, 32'h0, 1'b0);
    send_item(ActQueryAlt, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b0);
    // A zero speed is never stored; a clear on an empty table still answers.
    send_item(ActLoad, 32'sd5, 32'h0, 1'b0);
    send_item(ActClear, 32'sd0, 32'h0, 1'b0);
    // A single anchor gives its own speed wherever the query falls.
    send_item(ActLoad, 32'sd100, 32'h0001_0000, 1'b0);
    send_item(ActQuery, -32'sd5, 32'h0, 1'b0);
    // Anchors at both ends of the position range, with the extreme speeds.
    send_item(ActLoad, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_item(ActLoad, 32'sh7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_item(ActQuery, 32'sh8000_0000, 32'h0, 1'b0);
    send_item(ActQuery, 32'sh7FFF_FFFF, 32'h0, 1'b0);
    send_item(ActQuery, 32'sd0, 32'h0, 1'b0);
    send_item(ActQuery, 32'sd1000, 32'h0, 1'b0);
    // Two anchors on one inner position: the first loaded one wins there.
    send_item(ActLoad, 32'sd100, 32'h0002_0000, 1'b0);
    send_item(ActQuery, 32'sd100, 32'h0, 1'b0);
    send_item(ActQuery, 32'sd50, 32'h0, 1'b0);
    // Ties at the outer ends: last loaded at the top, first loaded at the bottom.
    send_item(ActLoad, 32'sh7FFF_FFFF, 32'h0000_0005, 1'b0);
    send_item(ActQuery, 32'sh7FFF_FFFF, 32'h0, 1'b0);
    send_item(ActLoad, 32'sh8000_0000, 32'h0000_0007, 1'b0);
    send_item(ActQuery, 32'sh8000_0000, 32'h0, 1'b0);
    // Fill the table, then try one more load, which must be dropped.
    send_item(ActLoad, 32'sd200, 32'h7FFF_0000, 1'b0);
    send_item(ActLoad, 32'sd300, 32'h0000_0001, 1'b0);
    send_item(ActLoad, 32'sd0, 32'h0000_0009, 1'b0);
    send_item(ActQuery, 32'sd250, 32'h0, 1'b0);
    send_item(ActClear, 32'sd0, 32'h0, 1'b0);
    send_item(ActQuery, 32'sd7, 32'h0, 1'b0);

    // The extreme fallback values, each read back from an empty table.
    wait_drained();
    write_fallback(32'hFFFF_FFFF);
    send_item(ActQuery, $urandom, $urandom, 1'b0);
    wait_drained();
    write_fallback(32'h0000_0000);
    send_item(ActQueryAlt, $urandom, $urandom, 1'b0);

    // Back-pressure: a few anchors, then a burst of queries against a long receiver
    // hold-off, so the block fills up; afterwards the sender waits for every answer.
    repeat (4) send_item(ActLoad, int'($urandom_range(0, 4000)) - 2000, pick_speed(), 1'b0);
    hold_off_req = 1'b1;
    repeat (16) send_item(ActQuery, pick_query_pos(), $urandom, 1'b1);
    wait_drained();

    // Random part: each phase is a clear, a run of loads and a run of queries, with
    // stray loads, clears and zero-speed loads mixed in as noise. Sometimes the phase
    // first waits for the block to drain and changes the fallback speed.
    n_random = 0;
    while (n_random < RandomItems) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_drained();
        case ($urandom_range(0, 2))
          0:       write_fallback(32'h0000_0000);
          1:       write_fallback(32'hFFFF_FFFF);
          default: write_fallback($urandom);
        endcase
      end
      phase_burst = ($urandom_range(0, 3) == 0);
      send_item(ActClear, $urandom, $urandom, phase_burst);
      n_random++;

      n_loads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : $urandom_range(2, 8);
      repeat (n_loads) begin
        case ($urandom_range(0, 4))
          0:       load_pos = $urandom;
          1, 2:    load_pos = int'($urandom_range(0, 4000)) - 2000;
          3:       load_pos = (anchor_pos_q.size() != 0) ?
                              anchor_pos_q[$urandom_range(0, anchor_pos_q.size() - 1)] :
                              $urandom;
          default: load_pos = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
        // Zero-speed loads are only noise and do not count toward the total.
        if ($urandom_range(0, 9) == 0) begin
          send_item(ActLoad, load_pos, 32'h0, phase_burst);
        end else begin
          send_item(ActLoad, load_pos, pick_speed(), phase_burst);
          n_random++;
        end
      end

      n_queries = $urandom_range(4, 24);
      repeat (n_queries) begin
        case ($urandom_range(0, 19))
          0:       send_item(ActLoad, pick_query_pos(), pick_speed(), phase_burst);
          1:       send_item(ActClear, $urandom, $urandom, phase_burst);
          2:       send_item(ActQueryAlt, pick_query_pos(), $urandom, phase_burst);
          default: send_item(ActQuery, pick_query_pos(), $urandom, phase_burst);
        endcase
        n_random++;
      end
    end

    // Let every answer arrive, then watch a little longer for anything stray.
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pls_pkg.sv
sv/piecewise_linear_speed_profile_unit.sv
tb/pls_profile_checker.sv
tb/tb.sv
